### rtl/lfse_pkg.sv
// ----------------------------------------------------------------------------
// lfse_pkg
// Shared types and codes for the list / fifo / stack entry store.
// ----------------------------------------------------------------------------
package lfse_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_KEEP   = 3'd3,
		CMD_DROP   = 3'd4,
		CMD_CLEAR  = 3'd5,
		CMD_READ   = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FULL  = 3'd2,
		ST_MODE  = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

	localparam logic [1:0] MODE_LIST  = 2'd0;
	localparam logic [1:0] MODE_FIFO  = 2'd1;
	localparam logic [1:0] MODE_STACK = 2'd2;

endpackage

### rtl/lfse_ram.sv
// ----------------------------------------------------------------------------
// lfse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/lfse_addr_unit.sv
// ----------------------------------------------------------------------------
// lfse_addr_unit
// Shared address unit: maps a logical entry index onto the circular store.
// ----------------------------------------------------------------------------
module lfse_addr_unit #(
	parameter int CAPACITY = 256
) (
	input  logic [$clog2(CAPACITY)-1:0]   head,
	input  logic [$clog2(CAPACITY+1)-1:0] offset,
	output logic [$clog2(CAPACITY)-1:0]   phys
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW:0] sum;
	logic [CW:0] wrapped;

	always_comb begin
		sum = (CW+1)'(head) + (CW+1)'(offset);
		if (sum >= (CW+1)'(CAPACITY)) begin
			wrapped = sum - (CW+1)'(CAPACITY);
		end else begin
			wrapped = sum;
		end
	end

	assign phys = wrapped[AW-1:0];

endmodule

### rtl/list_fifo_stack_engine_unit.sv
// ----------------------------------------------------------------------------
// list_fifo_stack_engine_unit
// Ordered entry store used as plain list, fifo or stack, one request at a time.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ group: s_tuser carries the command, s_tdata the
// entry value and the position. Each request gives one result on the m_
// group: status and data-valid flag in m_tuser, entry value and fill count
// in m_tdata. The mode register is written through cfg_we / cfg_wdata.
// Entries live in a circular RAM addressed through one shared adder with a
// wrap correction, so fifo pop and drop-before only move the head pointer.
// Push, pop, keep, drop, clear and read pass an execute state, which runs
// the RAM access, and a result state, which presents the result while the
// next request is taken. Delete at index moves entries behind it one RAM
// read and one RAM write at a time.
// A result sits in the output register until m_tready; while it waits a
// new request is taken only in the idle state, and the result stage holds.
// Reset clears the fill count, head pointer, mode and output valid; the RAM
// itself is not cleared, entries beyond the fill count are never read.
// ----------------------------------------------------------------------------
module list_fifo_stack_engine_unit #(
	parameter int CAPACITY   = 256,
	parameter int ENTRY_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,   // cmd
	input  logic [71:0] s_tdata,   // data_in[63:0], position[71:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [3:0]  m_tuser,   // status[2:0], data_valid[3]
	output logic [79:0] m_tdata    // data_out[63:0], count_out[72:64], zero pad
);

	import lfse_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 8) ? CW : 8;
	localparam int OW = (CW > 9) ? CW : 9;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_MVRD = 5'b00100,
		S_MVWR = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t                state_q;
	logic [1:0]            mode_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         head_q;
	cmd_t                  cmd_q;
	status_t               status_q;
	logic                  do_q;
	logic [CW-1:0]         idx_q;
	logic [ENTRY_BITS-1:0] din_q;

	status_t               out_status_q;
	logic                  out_valid_q;
	logic [63:0]           out_data_q;
	logic [8:0]            out_count_q;
	logic                  m_tvalid_q;

	status_t               st_d;
	logic                  do_d;
	logic [CW-1:0]         idx_d;
	logic [XW-1:0]         pos_x;
	logic [XW-1:0]         cnt_x;
	logic                  is_fifo;
	logic                  is_stack;

	logic                  slot_free;
	logic                  accept;
	logic                  fifo_pop;
	logic [CW-1:0]         offset;
	logic [AW-1:0]         phys;
	logic                  ram_we;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [ENTRY_BITS-1:0] ram_wdata;
	logic [ENTRY_BITS-1:0] ram_rdata;
	logic [CW:0]           next_chk;
	logic [OW-1:0]         cnt_o;
	logic                  hit_valid;

	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) || ((state_q == S_RESP) && slot_free);
	assign accept    = s_tvalid && s_tready;
	assign is_fifo   = (mode_q == MODE_FIFO);
	assign is_stack  = (mode_q == MODE_STACK);
	assign pos_x     = XW'(s_tdata[71:64]);
	assign cnt_x     = XW'(count_q);

	// request decode against the current fill state
	always_comb begin
		st_d  = ST_OK;
		do_d  = 1'b0;
		idx_d = pos_x[CW-1:0];
		unique case (s_tuser)
			CMD_PUSH: begin
				idx_d = count_q;
				if (!is_fifo && !is_stack) begin
					st_d = ST_MODE;
				end else if (count_q >= CW'(CAPACITY)) begin
					st_d = ST_FULL;
				end else begin
					do_d = 1'b1;
				end
			end
			CMD_POP: begin
				idx_d = is_fifo ? CW'(1) : (count_q - CW'(1));
				if (!is_fifo && !is_stack) begin
					st_d = ST_MODE;
				end else if (count_q == '0) begin
					st_d = ST_EMPTY;
				end else begin
					do_d = 1'b1;
				end
			end
			CMD_DELETE, CMD_KEEP, CMD_READ: begin
				if (count_q == '0) begin
					st_d = ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					st_d = ST_RANGE;
				end else begin
					do_d = 1'b1;
				end
			end
			CMD_DROP: begin
				if (pos_x == '0) begin
					st_d = ST_OK;
				end else if (count_q == '0) begin
					st_d = ST_EMPTY;
				end else if (pos_x > cnt_x) begin
					st_d = ST_RANGE;
				end else begin
					do_d = 1'b1;
				end
			end
			CMD_CLEAR: begin
				do_d = 1'b1;
			end
			default: begin
				do_d = 1'b0;
			end
		endcase
	end

	assign fifo_pop  = (cmd_q == CMD_POP) && is_fifo;
	assign offset    = (state_q == S_MVRD) ? (idx_q + CW'(1)) : idx_q;
	assign ram_raddr = fifo_pop ? head_q : phys;
	assign ram_wdata = (state_q == S_MVWR) ? ram_rdata : din_q;
	assign ram_we    = ((state_q == S_EXEC) && do_q && (cmd_q == CMD_PUSH))
		|| (state_q == S_MVWR);
	assign ram_re    = ((state_q == S_EXEC) && do_q
		&& ((cmd_q == CMD_POP) || (cmd_q == CMD_READ)))
		|| (state_q == S_MVRD);

	lfse_addr_unit #(
		.CAPACITY(CAPACITY)
	) u_addr (
		.head  (head_q),
		.offset(offset),
		.phys  (phys)
	);

	lfse_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(phys),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (state_q == S_EXEC) begin
			next_chk = (CW+1)'(idx_q) + (CW+1)'(1);
		end else begin
			next_chk = (CW+1)'(idx_q) + (CW+1)'(2);
		end
	end

	assign cnt_o     = OW'(count_q);
	assign hit_valid = do_q && ((cmd_q == CMD_POP) || (cmd_q == CMD_READ));

	// sequencer and store state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_LIST;
			count_q    <= '0;
			head_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if ((state_q == S_RESP) && slot_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (do_q && (cmd_q == CMD_DELETE)
						&& (next_chk < (CW+1)'(count_q))) begin
						state_q <= S_MVRD;
					end else begin
						state_q <= S_RESP;
					end
					if (do_q) begin
						case (cmd_q)
							CMD_PUSH: count_q <= count_q + CW'(1);
							CMD_POP: begin
								count_q <= count_q - CW'(1);
								if (is_fifo) begin
									head_q <= phys;
								end
							end
							CMD_DELETE: begin
								if (next_chk >= (CW+1)'(count_q)) begin
									count_q <= count_q - CW'(1);
								end
							end
							CMD_KEEP: count_q <= idx_q + CW'(1);
							CMD_DROP: begin
								head_q  <= phys;
								count_q <= count_q - idx_q;
							end
							CMD_CLEAR: count_q <= '0;
							default: begin
								count_q <= count_q;
							end
						endcase
					end
				end
				S_MVRD: begin
					state_q <= S_MVWR;
				end
				S_MVWR: begin
					if (next_chk < (CW+1)'(count_q)) begin
						state_q <= S_MVRD;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (slot_free) begin
						state_q <= accept ? S_EXEC : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_t'(s_tuser);
			status_q <= st_d;
			do_q     <= do_d;
			idx_q    <= idx_d;
			din_q    <= s_tdata[ENTRY_BITS-1:0];
		end else if (state_q == S_MVWR) begin
			idx_q <= idx_q + CW'(1);
		end
		if ((state_q == S_RESP) && slot_free) begin
			out_status_q <= status_q;
			out_valid_q  <= hit_valid;
			out_data_q   <= hit_valid ? 64'(ram_rdata) : 64'd0;
			out_count_q  <= cnt_o[8:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = {out_valid_q, out_status_q};
	assign m_tdata  = {7'd0, out_count_q, out_data_q};

endmodule

### rtl/lfse_checker.sv
// ----------------------------------------------------------------------------
// lfse_checker
// Port-level checks for the list / fifo / stack entry store.
// ----------------------------------------------------------------------------
module lfse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [3:0]  m_tuser,
	input logic [79:0] m_tdata
);

	import lfse_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// entry data only comes with ok status
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tuser[2:0] == ST_OK)
		else $error("data valid with error status");

	// no entry means zero data
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[3] |-> m_tdata[63:0] == 64'd0)
		else $error("data without valid flag");

	// status is a known code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[2:0] == ST_OK || m_tuser[2:0] == ST_EMPTY
			|| m_tuser[2:0] == ST_FULL || m_tuser[2:0] == ST_MODE
			|| m_tuser[2:0] == ST_RANGE)
		else $error("unknown status code");

endmodule

bind list_fifo_stack_engine_unit lfse_checker u_lfse_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tuser (m_tuser),
	.m_tdata (m_tdata)
);
